// ----- rtl/dojq_pkg.sv -----
// Shared constants, types and helper functions for the deadline-ordered job queue.
package dojq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW          = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W        = 8;
	localparam int DL_W        = 33;
	localparam int HELD_W      = 5;
	localparam int STATUS_W    = 3;

	typedef logic [AW-1:0]   addr_t;
	typedef logic [CW-1:0]   cnt_t;
	typedef logic [ID_W-1:0] id_t;
	typedef logic [DL_W-1:0] dl_t;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_TICK   = 2'd2
	} req_code_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED   = 3'd0,
		ST_REMOVED    = 3'd1,
		ST_DISPATCHED = 3'd2,
		ST_EMPTY      = 3'd3,
		ST_NOT_DUE    = 3'd4,
		ST_FULL       = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		RD_HEAD   = 2'd0,
		RD_POS_M1 = 2'd1,
		RD_POS_M2 = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic    cap_req;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    pos_init;
		logic    pos_dec;
		logic    wr_shift;
		logic    wr_new;
		logic    cnt_inc;
		logic    pop;
		logic    res_load;
		status_t res_status;
		logic    res_job;
	} dp_cmd_t;

	typedef struct packed {
		logic is_insert;
		logic is_remove;
		logic full;
		logic empty;
		logic pos_zero;
		logic pos_one;
		logic shift_ok;
		logic due;
		logic out_free;
	} dp_sts_t;

	function automatic addr_t phys_addr(input addr_t head, input addr_t lg);
		logic [AW:0] sum;
		sum = {1'b0, head} + {1'b0, lg};
		if (sum >= (AW+1)'(QUEUE_DEPTH))
			sum = sum - (AW+1)'(QUEUE_DEPTH);
		return sum[AW-1:0];
	endfunction

	function automatic addr_t wrap_inc(input addr_t a);
		addr_t r;
		if ({1'b0, a} == (AW+1)'(QUEUE_DEPTH - 1))
			r = '0;
		else
			r = a + addr_t'(1);
		return r;
	endfunction

endpackage

// ----- rtl/dojq_ctrl.sv -----
// Sequencing state machine for the job queue: decode, sorted insert walk, head check, result.
module dojq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  dojq_pkg::dp_sts_t sts,
	output dojq_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_WR,
		S_HEAD_CHK,
		S_FINISH
	} state_t;

	state_t              state_q;
	state_t              state_d;
	dojq_pkg::status_t   res_status_q;
	dojq_pkg::status_t   res_status_d;
	logic                res_job_q;
	logic                res_job_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.rd_sel     = dojq_pkg::RD_HEAD;
		cmd.res_status = res_status_q;
		cmd.res_job    = res_job_q;
		state_d        = state_q;
		res_status_d   = res_status_q;
		res_job_d      = res_job_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.cap_req = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.is_insert) begin
					if (sts.full) begin
						res_status_d = dojq_pkg::ST_FULL;
						res_job_d    = 1'b0;
						state_d      = S_FINISH;
					end else begin
						cmd.pos_init = 1'b1;
						state_d      = S_INS_RD;
					end
				end else if (sts.empty) begin
					res_status_d = dojq_pkg::ST_EMPTY;
					res_job_d    = 1'b0;
					state_d      = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = dojq_pkg::RD_HEAD;
					state_d    = S_HEAD_CHK;
				end
			end
			S_INS_RD: begin
				if (sts.pos_zero) begin
					state_d = S_INS_WR;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = dojq_pkg::RD_POS_M1;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (sts.shift_ok) begin
					cmd.wr_shift = 1'b1;
					cmd.pos_dec  = 1'b1;
					if (sts.pos_one) begin
						state_d = S_INS_WR;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = dojq_pkg::RD_POS_M2;
					end
				end else begin
					state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				cmd.wr_new   = 1'b1;
				cmd.cnt_inc  = 1'b1;
				res_status_d = dojq_pkg::ST_INSERTED;
				res_job_d    = 1'b0;
				state_d      = S_FINISH;
			end
			S_HEAD_CHK: begin
				if (sts.is_remove) begin
					cmd.pop      = 1'b1;
					res_status_d = dojq_pkg::ST_REMOVED;
					res_job_d    = 1'b1;
				end else if (sts.due) begin
					cmd.pop      = 1'b1;
					res_status_d = dojq_pkg::ST_DISPATCHED;
					res_job_d    = 1'b1;
				end else begin
					res_status_d = dojq_pkg::ST_NOT_DUE;
					res_job_d    = 1'b0;
				end
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			res_status_q <= dojq_pkg::ST_INSERTED;
			res_job_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			res_status_q <= res_status_d;
			res_job_q    <= res_job_d;
		end
	end

endmodule

// ----- rtl/dojq_dp.sv -----
// Datapath of the job queue: request registers, circular job memory, walk pointer, result register.
module dojq_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dojq_pkg::dp_cmd_t               cmd,
	output dojq_pkg::dp_sts_t               sts,
	input  logic [1:0]                      req_type,
	input  logic [dojq_pkg::ID_W-1:0]       job_id,
	input  logic [31:0]                     submit_time,
	input  logic [15:0]                     start_delay,
	input  logic [dojq_pkg::DL_W-1:0]       current_time,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [dojq_pkg::STATUS_W-1:0]   status,
	output logic [dojq_pkg::ID_W-1:0]       job_id_out,
	output logic [dojq_pkg::DL_W-1:0]       deadline_out,
	output logic [dojq_pkg::HELD_W-1:0]     jobs_held
);

	localparam int EW = dojq_pkg::ID_W + dojq_pkg::DL_W;

	logic [1:0]           req_type_q;
	dojq_pkg::id_t        new_id_q;
	dojq_pkg::dl_t        new_dl_q;
	dojq_pkg::dl_t        now_q;
	dojq_pkg::addr_t      head_q;
	dojq_pkg::cnt_t       cnt_q;
	dojq_pkg::cnt_t       pos_q;
	logic [EW-1:0]        mem_q [dojq_pkg::QUEUE_DEPTH];
	logic [EW-1:0]        rd_q;
	dojq_pkg::addr_t      rd_lg;
	dojq_pkg::addr_t      rd_addr;
	dojq_pkg::addr_t      wr_addr;
	logic                 wr_en;
	logic [EW-1:0]        wr_data;
	dojq_pkg::id_t        rd_id;
	dojq_pkg::dl_t        rd_dl;
	dojq_pkg::cnt_t       pos_m1;
	dojq_pkg::cnt_t       pos_m2;
	logic                 rsp_valid_q;
	logic [dojq_pkg::STATUS_W-1:0] status_q;
	dojq_pkg::id_t        job_id_out_q;
	dojq_pkg::dl_t        deadline_out_q;
	logic [dojq_pkg::HELD_W-1:0]   jobs_held_q;

	assign rd_id  = rd_q[EW-1 -: dojq_pkg::ID_W];
	assign rd_dl  = rd_q[dojq_pkg::DL_W-1:0];
	assign pos_m1 = pos_q - dojq_pkg::cnt_t'(1);
	assign pos_m2 = pos_q - dojq_pkg::cnt_t'(2);

	always_comb begin
		case (cmd.rd_sel)
			dojq_pkg::RD_HEAD:   rd_lg = '0;
			dojq_pkg::RD_POS_M1: rd_lg = pos_m1[dojq_pkg::AW-1:0];
			dojq_pkg::RD_POS_M2: rd_lg = pos_m2[dojq_pkg::AW-1:0];
			default:             rd_lg = '0;
		endcase
	end

	assign rd_addr = dojq_pkg::phys_addr(head_q, rd_lg);
	assign wr_addr = dojq_pkg::phys_addr(head_q, pos_q[dojq_pkg::AW-1:0]);
	assign wr_en   = cmd.wr_shift | cmd.wr_new;
	assign wr_data = cmd.wr_new ? {new_id_q, new_dl_q} : rd_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (cmd.rd_en)
			rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_req) begin
			req_type_q <= req_type;
			new_id_q   <= job_id;
			new_dl_q   <= {1'b0, submit_time} + {17'd0, start_delay};
			now_q      <= current_time;
		end
		if (cmd.pos_init)
			pos_q <= cnt_q;
		else if (cmd.pos_dec)
			pos_q <= pos_m1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.cnt_inc)
				cnt_q <= cnt_q + dojq_pkg::cnt_t'(1);
			else if (cmd.pop) begin
				cnt_q  <= cnt_q - dojq_pkg::cnt_t'(1);
				head_q <= dojq_pkg::wrap_inc(head_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q       <= cmd.res_status;
			job_id_out_q   <= cmd.res_job ? rd_id : '0;
			deadline_out_q <= cmd.res_job ? rd_dl : '0;
			jobs_held_q    <= dojq_pkg::HELD_W'(cnt_q);
		end
	end

	assign sts.is_insert = (req_type_q == dojq_pkg::REQ_INSERT);
	assign sts.is_remove = (req_type_q == dojq_pkg::REQ_REMOVE);
	assign sts.full      = (cnt_q == dojq_pkg::cnt_t'(dojq_pkg::QUEUE_DEPTH));
	assign sts.empty     = (cnt_q == '0);
	assign sts.pos_zero  = (pos_q == '0);
	assign sts.pos_one   = (pos_q == dojq_pkg::cnt_t'(1));
	assign sts.shift_ok  = (rd_dl >= new_dl_q);
	assign sts.due       = (now_q >= rd_dl);
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign job_id_out   = job_id_out_q;
	assign deadline_out = deadline_out_q;
	assign jobs_held    = jobs_held_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= dojq_pkg::cnt_t'(dojq_pkg::QUEUE_DEPTH))
		else $error("job count above queue depth");
	a_no_inc_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !sts.full)
		else $error("insert committed into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !sts.empty)
		else $error("head taken from an empty queue");
	a_shift_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_shift |-> $past(cmd.rd_en))
		else $error("shift write without a fresh read");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> sts.out_free)
		else $error("result loaded over an untaken word");
`endif

endmodule

// ----- rtl/deadline_ordered_job_queue_unit.sv -----
// Top level of the deadline-ordered job queue: request and response word channels.
// One request word yields one response word. A remove or tick on a non-empty queue goes
// from decode through the head check to the result state, an empty or full case from decode
// straight to the result state, and an insert through decode, a first read, compare steps
// that move back every queued job whose deadline is at or after the new one, and the write
// of the new entry; the insert walk shifts one entry per cycle through the single-write,
// single-read job memory. A new request word is taken while the previous response word
// still waits in the output register.
module deadline_ordered_job_queue_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [1:0]                      req_type,
	input  logic [dojq_pkg::ID_W-1:0]       job_id,
	input  logic [31:0]                     submit_time,
	input  logic [15:0]                     start_delay,
	input  logic [dojq_pkg::DL_W-1:0]       current_time,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [dojq_pkg::STATUS_W-1:0]   status,
	output logic [dojq_pkg::ID_W-1:0]       job_id_out,
	output logic [dojq_pkg::DL_W-1:0]       deadline_out,
	output logic [dojq_pkg::HELD_W-1:0]     jobs_held
);

	dojq_pkg::dp_cmd_t cmd;
	dojq_pkg::dp_sts_t sts;

	dojq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dojq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.job_id       (job_id),
		.submit_time  (submit_time),
		.start_delay  (start_delay),
		.current_time (current_time),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.status       (status),
		.job_id_out   (job_id_out),
		.deadline_out (deadline_out),
		.jobs_held    (jobs_held)
	);

endmodule
